// ===== rtl/core/idnc_pkg.sv =====
`default_nettype none
package idnc_pkg;

	localparam int unsigned NAME_LIMIT = 64;
	localparam int unsigned LOCAL_LEN  = 9;

	typedef enum logic [1:0] {
		ST_NUMERIC = 2'd0,
		ST_LOCAL   = 2'd1,
		ST_LOOKUP  = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] octet0;
		logic [7:0] octet1;
		logic [7:0] octet2;
		logic [7:0] octet3;
	} result_t;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_DOT  = 8'h2e;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] OCT_MAX = 8'd255;
	localparam logic [7:0] LOOPBACK_HI = 8'd127;
	localparam logic [7:0] LOOPBACK_LO = 8'd1;

	// "localhost", one character per position
	function automatic logic [7:0] local_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:    c = 8'h6c;
			4'd1:    c = 8'h6f;
			4'd2:    c = 8'h63;
			4'd3:    c = 8'h61;
			4'd4:    c = 8'h6c;
			4'd5:    c = 8'h68;
			4'd6:    c = 8'h6f;
			4'd7:    c = 8'h73;
			4'd8:    c = 8'h74;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/idnc_scan.sv =====
`default_nettype none
module idnc_scan (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   step,
	input  wire  [7:0]            ch,
	output idnc_pkg::result_t     result
);

	logic [7:0] acc_q;
	logic [1:0] dot_q;
	logic [7:0] store0_q, store1_q, store2_q;
	logic       num_q;
	logic       inv_q;
	logic [7:0] cnt_q;
	logic       lh_q;

	logic       is_term;
	logic       is_digit;
	logic       is_dot;
	logic [3:0] digit;
	logic [11:0] acc_x10;
	logic       lh_hit;
	logic       scan_on;

	assign is_term  = (ch == idnc_pkg::CH_NUL);
	assign is_digit = (ch >= idnc_pkg::CH_ZERO) && (ch <= idnc_pkg::CH_NINE);
	assign is_dot   = (ch == idnc_pkg::CH_DOT);
	assign digit    = 4'(ch - idnc_pkg::CH_ZERO);
	assign acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {8'h00, digit};
	assign lh_hit   = (cnt_q < 8'(idnc_pkg::LOCAL_LEN)) &&
	                  (idnc_pkg::local_char(cnt_q[3:0]) == ch);
	assign scan_on  = num_q && !inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			dot_q <= '0;
			num_q <= 1'b1;
			inv_q <= 1'b0;
			cnt_q <= '0;
			lh_q  <= 1'b1;
		end else if (step) begin
			if (is_term) begin
				acc_q <= '0;
				dot_q <= '0;
				num_q <= 1'b1;
				inv_q <= 1'b0;
				cnt_q <= '0;
				lh_q  <= 1'b1;
			end else begin
				if (lh_q && !lh_hit)
					lh_q <= 1'b0;
				if (cnt_q != idnc_pkg::OCT_MAX)
					cnt_q <= cnt_q + 8'd1;
				if (scan_on) begin
					if (is_digit) begin
						if (acc_x10 > 12'd255)
							inv_q <= 1'b1;
						else
							acc_q <= acc_x10[7:0];
					end else if (is_dot) begin
						if (dot_q == 2'd3) begin
							inv_q <= 1'b1;
						end else begin
							acc_q <= '0;
							dot_q <= dot_q + 2'd1;
						end
					end else begin
						num_q <= 1'b0;
					end
				end
			end
		end
	end

	// closed octets, rewritten for every name before they are used
	always_ff @(posedge clk) begin
		if (step && !is_term && scan_on && !is_digit && is_dot) begin
			case (dot_q)
				2'd0:    store0_q <= acc_q;
				2'd1:    store1_q <= acc_q;
				2'd2:    store2_q <= acc_q;
				default: ;
			endcase
		end
	end

	always_comb begin
		result = '0;
		if (cnt_q == 8'd0) begin
			result.status = idnc_pkg::ST_INVALID;
		end else if (lh_q && cnt_q == 8'(idnc_pkg::LOCAL_LEN)) begin
			result.status = idnc_pkg::ST_LOCAL;
			result.octet0 = idnc_pkg::LOOPBACK_HI;
			result.octet3 = idnc_pkg::LOOPBACK_LO;
		end else if (inv_q) begin
			result.status = idnc_pkg::ST_INVALID;
		end else if (num_q && dot_q == 2'd3) begin
			result.status = idnc_pkg::ST_NUMERIC;
			result.octet0 = store0_q;
			result.octet1 = store1_q;
			result.octet2 = store2_q;
			result.octet3 = acc_q;
		end else if (cnt_q > 8'(idnc_pkg::NAME_LIMIT)) begin
			result.status = idnc_pkg::ST_INVALID;
		end else begin
			result.status = idnc_pkg::ST_LOOKUP;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ipv4_dotted_name_classifier.sv =====
// Host name classifier.
// Input channel (in_valid, in_stall, ch): one character per item, a zero
// character ends the name. Output channel (out_valid, out_stall, status,
// octet0..octet3): one item per name, produced by its terminator; no item
// for other characters. Status 0 is a dotted numeric address, 1 the name
// "localhost" (127.0.0.1), 2 a name that needs a lookup, 3 invalid.
// Octets are zero for status 2 and 3.
// Throughput: one character per cycle while in_stall is low and no
// terminator waits on a stalled output. A character waits in a two-entry
// input buffer and is folded into the scan state at the edge where it
// leaves the buffer; the result is loaded into the output register, and
// out_valid is set, at the edge where the terminator leaves the buffer.
// A stalled output holds its item; characters keep flowing while the result
// waits, and only a terminator waits behind it. in_stall rises once the
// input buffer holds two characters.
// Reset clears the buffer, the scan state and the output valid, so the
// block starts at the beginning of a name.
`default_nettype none
module ipv4_dotted_name_classifier (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] ch,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [1:0] status,
	output logic [7:0] octet0,
	output logic [7:0] octet1,
	output logic [7:0] octet2,
	output logic [7:0] octet3
);

	logic [7:0] buf0_q, buf1_q;
	logic [1:0] fill_q;
	logic       push, pop, head_term, out_free, can_go;
	idnc_pkg::result_t res;
	idnc_pkg::result_t out_q;
	logic       out_valid_q;

	assign in_stall  = (fill_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign head_term = (buf0_q == idnc_pkg::CH_NUL);
	assign out_free  = !out_valid_q || !out_stall;
	assign can_go    = !head_term || out_free;
	assign pop       = (fill_q != 2'd0) && can_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (fill_q == 2'd1)
				buf0_q <= ch;
			else
				buf0_q <= buf1_q;
			if (fill_q == 2'd2)
				buf1_q <= ch;
		end else if (pop) begin
			buf0_q <= buf1_q;
		end else if (push) begin
			if (fill_q == 2'd0)
				buf0_q <= ch;
			else
				buf1_q <= ch;
		end
	end

	idnc_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (pop),
		.ch     (buf0_q),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop && head_term)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop && head_term)
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign status    = out_q.status;
	assign octet0    = out_q.octet0;
	assign octet1    = out_q.octet1;
	assign octet2    = out_q.octet2;
	assign octet3    = out_q.octet3;

endmodule
`default_nettype wire

// ===== rtl/core/idnc_checker.sv =====
`default_nettype none
module idnc_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_stall,
	input wire [7:0] ch,
	input wire       out_valid,
	input wire       out_stall,
	input wire [1:0] status,
	input wire [7:0] octet0,
	input wire [7:0] octet1,
	input wire [7:0] octet2,
	input wire [7:0] octet3
);

	logic [31:0] addr;
	assign addr = {octet0, octet1, octet2, octet3};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(addr))
		else $error("stalled result item changed");

	a_loopback: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == idnc_pkg::ST_LOCAL |->
			octet0 == 8'd127 && octet1 == 8'd0 && octet2 == 8'd0 && octet3 == 8'd1)
		else $error("loopback item with wrong address");

	a_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == idnc_pkg::ST_LOOKUP || status == idnc_pkg::ST_INVALID) |->
			addr == 32'd0)
		else $error("address bytes set on lookup or invalid item");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stall rose without an accepted item");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall, 1) || $past(in_valid && !in_stall, 2) ||
			$past(in_stall, 2) || $past(out_valid, 2))
		else $error("result item without a preceding input item");

endmodule

bind ipv4_dotted_name_classifier idnc_checker u_idnc_checker (.*);
`default_nettype wire
